### design/sbls_pkg.sv
// sbls_pkg: shared types and constants for the 16-bit load and stack unit
// opcode codes, decode masks, machine cycle counts and the result word type
// no dependencies
package sbls_pkg;

    // opcode decode masks
    localparam logic [7:0] OP_GROUP_MASK = 8'hCF;
    localparam logic [7:0] PAIR_FIELD    = 8'h30;
    localparam logic [7:0] NIBBLE_HI     = 8'hF0;

    // opcodes, with the pair field cleared for the grouped ones
    localparam logic [7:0] OP_LD_RR_NN = 8'h01;
    localparam logic [7:0] OP_LD_SP_HL = 8'hF9;
    localparam logic [7:0] OP_PUSH     = 8'hC5;
    localparam logic [7:0] OP_POP      = 8'hC1;
    localparam logic [7:0] OP_LDHL     = 8'hF8;
    localparam logic [7:0] OP_LD_NN_SP = 8'h08;

    // pair select codes from the pair field
    localparam logic [1:0] SEL_BC = 2'd0;
    localparam logic [1:0] SEL_DE = 2'd1;
    localparam logic [1:0] SEL_HL = 2'd2;
    localparam logic [1:0] SEL_AF = 2'd3;

    // machine cycle counts
    localparam logic [2:0] MC_NONE     = 3'd0;
    localparam logic [2:0] MC_LD_RR_NN = 3'd3;
    localparam logic [2:0] MC_LD_SP_HL = 3'd2;
    localparam logic [2:0] MC_PUSH     = 3'd4;
    localparam logic [2:0] MC_POP      = 3'd3;
    localparam logic [2:0] MC_LDHL     = 3'd3;
    localparam logic [2:0] MC_LD_NN_SP = 3'd5;

    // status codes
    localparam logic ST_OK          = 1'b0;
    localparam logic ST_UNSUPPORTED = 1'b1;

    // one result word
    typedef struct packed {
        logic        status;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
        logic [2:0]  machine_cycles;
        logic [15:0] sp_after;
        logic [15:0] bc_after;
        logic [15:0] de_after;
        logic [15:0] hl_after;
        logic [15:0] af_after;
    } t_result;

endpackage

### design/sbls_if.sv
// sbls_if: valid/ready channel interfaces for the instruction and result words
// no dependencies
interface sbls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode_byte;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] pop_low;
    logic [7:0] pop_high;

    modport source(output valid, opcode_byte, imm_low, imm_high, pop_low, pop_high,
                   input ready);
    modport sink(input valid, opcode_byte, imm_low, imm_high, pop_low, pop_high,
                 output ready);
endinterface

interface sbls_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last;
    logic [2:0]  machine_cycles;
    logic [15:0] sp_after;
    logic [15:0] bc_after;
    logic [15:0] de_after;
    logic [15:0] hl_after;
    logic [15:0] af_after;

    modport source(output valid, status, write_enable, write_address, write_data, last,
                   machine_cycles, sp_after, bc_after, de_after, hl_after, af_after,
                   input ready);
    modport sink(input valid, status, write_enable, write_address, write_data, last,
                 machine_cycles, sp_after, bc_after, de_after, hl_after, af_after,
                 output ready);
endinterface

### design/sixteen_bit_load_stack_unit.sv
// channel   | modport | word
// ----------+---------+------------------------------------------------------
// i_in      | sink    | opcode_byte, imm_low, imm_high, pop_low, pop_high
// o_out     | source  | status, write, last, machine_cycles, register pairs
//
// an instruction is decoded and executed in the cycle it is accepted; its
// results appear on o_out the next cycle. one-result instructions sustain one
// word per cycle while o_out is ready; push and ld (nn),sp give two words and
// hold off i_in until the single pending slot behind the output register has
// drained. i_rst_n (synchronous) clears the register file, sp and both output
// slots. a stalled o_out holds its word; i_in.ready drops while the pending
// slot is occupied or while the output word waits on a stalled o_out.
//
// 16-bit load and stack unit; uses sbls_pkg and sbls_if
module sixteen_bit_load_stack_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbls_in_if.sink    i_in,
    sbls_out_if.source o_out
);

    // architectural state
    logic [15:0] r_bc, r_de, r_hl, r_af, r_sp;
    logic [15:0] n_bc, n_de, n_hl, n_af, n_sp;

    // output register and pending second word
    sbls_pkg::t_result r_out, r_pend;
    logic              r_out_valid, r_pend_valid;
    sbls_pkg::t_result n_res1, n_res2;
    logic              n_two;

    logic accept;

    assign i_in.ready = !r_pend_valid && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // decode and execute
    always_comb begin
        logic [7:0]  op;
        logic [1:0]  sel;
        logic [7:0]  grp;
        logic [15:0] imm;
        logic [15:0] pair;
        logic [15:0] ext;
        logic [15:0] sum;
        logic [4:0]  half;
        logic [8:0]  full;
        logic        ok;
        logic        we;
        logic [15:0] addr1, addr2;
        logic [7:0]  data1, data2;
        logic [2:0]  mc;

        op    = i_in.opcode_byte;
        sel   = 2'((op & sbls_pkg::PAIR_FIELD) >> 4);
        grp   = op & sbls_pkg::OP_GROUP_MASK;
        imm   = {i_in.imm_high, i_in.imm_low};
        ext   = {{8{i_in.imm_low[7]}}, i_in.imm_low};
        sum   = r_sp + ext;
        half  = {1'b0, r_sp[3:0]} + {1'b0, i_in.imm_low[3:0]};
        full  = {1'b0, r_sp[7:0]} + {1'b0, i_in.imm_low};
        n_bc  = r_bc;
        n_de  = r_de;
        n_hl  = r_hl;
        n_af  = r_af;
        n_sp  = r_sp;
        ok    = 1'b1;
        we    = 1'b0;
        n_two = 1'b0;
        addr1 = '0;
        addr2 = '0;
        data1 = '0;
        data2 = '0;
        mc    = sbls_pkg::MC_NONE;

        // source pair for push
        case (sel)
            sbls_pkg::SEL_BC: pair = r_bc;
            sbls_pkg::SEL_DE: pair = r_de;
            sbls_pkg::SEL_HL: pair = r_hl;
            sbls_pkg::SEL_AF: pair = r_af;
            default:          pair = r_bc;
        endcase

        if (grp == sbls_pkg::OP_LD_RR_NN) begin
            mc = sbls_pkg::MC_LD_RR_NN;
            case (sel)
                sbls_pkg::SEL_BC: n_bc = imm;
                sbls_pkg::SEL_DE: n_de = imm;
                sbls_pkg::SEL_HL: n_hl = imm;
                sbls_pkg::SEL_AF: n_sp = imm;
                default:          n_sp = imm;
            endcase
        end else if (op == sbls_pkg::OP_LD_SP_HL) begin
            mc   = sbls_pkg::MC_LD_SP_HL;
            n_sp = r_hl;
        end else if (grp == sbls_pkg::OP_PUSH) begin
            mc    = sbls_pkg::MC_PUSH;
            we    = 1'b1;
            n_two = 1'b1;
            addr1 = r_sp - 16'd1;
            addr2 = r_sp - 16'd2;
            data1 = pair[15:8];
            data2 = pair[7:0];
            n_sp  = r_sp - 16'd2;
        end else if (grp == sbls_pkg::OP_POP) begin
            mc   = sbls_pkg::MC_POP;
            n_sp = r_sp + 16'd2;
            case (sel)
                sbls_pkg::SEL_BC: n_bc = {i_in.pop_high, i_in.pop_low};
                sbls_pkg::SEL_DE: n_de = {i_in.pop_high, i_in.pop_low};
                sbls_pkg::SEL_HL: n_hl = {i_in.pop_high, i_in.pop_low};
                sbls_pkg::SEL_AF: n_af = {i_in.pop_high, i_in.pop_low & sbls_pkg::NIBBLE_HI};
                default:          n_bc = {i_in.pop_high, i_in.pop_low};
            endcase
        end else if (op == sbls_pkg::OP_LDHL) begin
            // flags: half carry out of bit 3, carry out of bit 7
            mc   = sbls_pkg::MC_LDHL;
            n_hl = sum;
            n_af = {r_af[15:8], 2'b00, half[4], full[8], 4'b0000};
        end else if (op == sbls_pkg::OP_LD_NN_SP) begin
            mc    = sbls_pkg::MC_LD_NN_SP;
            we    = 1'b1;
            n_two = 1'b1;
            addr1 = imm;
            addr2 = imm + 16'd1;
            data1 = r_sp[7:0];
            data2 = r_sp[15:8];
        end else begin
            ok = 1'b0;
        end

        n_res1.status         = ok ? sbls_pkg::ST_OK : sbls_pkg::ST_UNSUPPORTED;
        n_res1.write_enable   = we;
        n_res1.write_address  = addr1;
        n_res1.write_data     = data1;
        n_res1.last           = !n_two;
        n_res1.machine_cycles = mc;
        n_res1.sp_after       = n_sp;
        n_res1.bc_after       = n_bc;
        n_res1.de_after       = n_de;
        n_res1.hl_after       = n_hl;
        n_res1.af_after       = n_af;

        n_res2               = n_res1;
        n_res2.write_address = addr2;
        n_res2.write_data    = data2;
        n_res2.last          = 1'b1;
    end

    // register file and stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= '0;
            r_de <= '0;
            r_hl <= '0;
            r_af <= '0;
            r_sp <= '0;
        end else if (accept) begin
            r_bc <= n_bc;
            r_de <= n_de;
            r_hl <= n_hl;
            r_af <= n_af;
            r_sp <= n_sp;
        end
    end

    // output slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= n_two;
        end else if (r_out_valid && o_out.ready) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    // output slot payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out  <= n_res1;
            r_pend <= n_res2;
        end else if (r_out_valid && o_out.ready && r_pend_valid) begin
            r_out <= r_pend;
        end
    end

    // drive result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.write_enable   = r_out.write_enable;
    assign o_out.write_address  = r_out.write_address;
    assign o_out.write_data     = r_out.write_data;
    assign o_out.last           = r_out.last;
    assign o_out.machine_cycles = r_out.machine_cycles;
    assign o_out.sp_after       = r_out.sp_after;
    assign o_out.bc_after       = r_out.bc_after;
    assign o_out.de_after       = r_out.de_after;
    assign o_out.hl_after       = r_out.hl_after;
    assign o_out.af_after       = r_out.af_after;

endmodule

### design/sbls_checker.sv
// sbls_checker: port-level assertions for the 16-bit load and stack unit
// bound to sixteen_bit_load_stack_unit; uses its interface ports only
module sbls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_status,
    input logic        i_write_enable,
    input logic [15:0] i_write_address,
    input logic [7:0]  i_write_data,
    input logic        i_last,
    input logic [2:0]  i_machine_cycles
);

    // reset empties the result channel
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_write_address)
            && $stable(i_write_data) && $stable(i_last))
        else $error("stalled result word changed");

    // unsupported opcode gives a single word with no write and machine_cycles cleared
    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_last && !i_write_enable
            && i_machine_cycles == 3'd0)
        else $error("unsupported word malformed");

    // once the first of two words is taken, its partner, a write, follows at once
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid && i_write_enable
            && i_last && $stable(i_machine_cycles))
        else $error("second write word missing");

endmodule

bind sixteen_bit_load_stack_unit sbls_checker u_sbls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_write_enable   (o_out.write_enable),
    .i_write_address  (o_out.write_address),
    .i_write_data     (o_out.write_data),
    .i_last           (o_out.last),
    .i_machine_cycles (o_out.machine_cycles)
);
